FILE: design/tqvg_pkg.sv
// Shared types, codes and helpers for the tile quad vertex generator.
// Depends on nothing; imported by tqvg_emit and tile_quad_vertex_generator.
package tqvg_pkg;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_CELL  = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    // Layout codes held in the orientation register.
    localparam logic [1:0] ORIENT_ORTHO = 2'd0;
    localparam logic [1:0] ORIENT_ISO   = 2'd1;
    localparam logic [1:0] ORIENT_HEX   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_ORIENTATION   = 3'd0;
    localparam logic [2:0] REG_TILE_COUNT    = 3'd1;
    localparam logic [2:0] REG_HEX_WIDTH     = 3'd2;
    localparam logic [2:0] REG_HEX_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd4;

    localparam logic [23:0] UNIT_Q8_16 = 24'h010000;

    // One accepted cell with the corner positions already worked out.
    // x0/x1 are the positions for corner offset 0/1, and the same for y.
    typedef struct packed {
        logic [1:0]         orient;
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic signed [31:0] y0;
        logic signed [31:0] y1;
        logic [10:0]        depth;
        logic [21:0]        base;
    } cell_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sh007FFFFFFF)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -40'sh0080000000)
        begin
            r = -32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Horizontal corner offset; the same for every layout.
    function automatic logic corner_px(input logic [1:0] c);
        return (c == 2'd1) || (c == 2'd2);
    endfunction

    // Vertical corner offset; the orthogonal layout walks the quad upside down.
    function automatic logic corner_py(input logic [1:0] orient, input logic [1:0] c);
        logic r;
        if (orient == ORIENT_ORTHO)
        begin
            r = (c == 2'd0) || (c == 2'd1);
        end
        else
        begin
            r = (c == 2'd2) || (c == 2'd3);
        end
        return r;
    endfunction

endpackage

FILE: design/tqvg_emit.sv
// Vertex emitter: texture coordinate table, corner sequencer and output register.
// Depends on tqvg_pkg for cell_t and the corner offset helpers.
module tqvg_emit
    import tqvg_pkg::*;
#(
    parameter int SLOT_W      = 10,
    parameter int TABLE_DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Cell hand-over from the front stage.
    input  logic                     cell_valid,
    input  cell_t                    cell_data,
    input  logic [SLOT_W-1:0]        cell_slot,
    output logic                     cell_take,
    output logic                     busy,
    // Table write port.
    input  logic                     wr_en,
    input  logic [SLOT_W+1:0]        wr_addr,
    input  logic [31:0]              wr_data,
    // Result channel.
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [31:0]       pos_x,
    output logic signed [31:0]       pos_y,
    output logic [10:0]              depth_step,
    output logic [15:0]              tex_u,
    output logic [15:0]              tex_v,
    output logic [21:0]              vertex_index,
    output logic [1:0]               corner,
    output logic                     last
);

    logic [31:0]        tbl_mem [TABLE_DEPTH];
    logic [31:0]        tbl_q_reg;

    logic               em_valid_reg, em_valid_next;
    logic [1:0]         em_corner_reg, em_corner_next;
    cell_t              em_cell_reg;
    logic [SLOT_W-1:0]  em_slot_reg;

    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_x_reg, out_y_reg;
    logic [10:0]        out_depth_reg;
    logic [21:0]        out_index_reg;
    logic [1:0]         out_corner_reg;
    logic               out_last_reg;

    logic               issue;
    logic               px, py;

    // A corner is issued whenever a cell is held and the output register is free or being emptied.
    assign issue     = em_valid_reg && (!out_valid_reg || !out_stall);
    assign cell_take = cell_valid && (!em_valid_reg || (issue && em_corner_reg == 2'd3));
    assign busy      = em_valid_reg;

    // Sequencer next state.
    always_comb
    begin
        em_valid_next  = em_valid_reg;
        em_corner_next = em_corner_reg;
        if (cell_take)
        begin
            em_valid_next  = 1'b1;
            em_corner_next = 2'd0;
        end
        else if (issue)
        begin
            em_valid_next  = (em_corner_reg != 2'd3);
            em_corner_next = em_corner_reg + 2'd1;
        end
    end

    // Output register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Corner offsets select the precomputed coordinates.
    assign px = corner_px(em_corner_reg);
    assign py = corner_py(em_cell_reg.orient, em_corner_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg  <= 1'b0;
            em_corner_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            em_valid_reg  <= em_valid_next;
            em_corner_reg <= em_corner_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Cell and vertex payload registers.
    always_ff @(posedge clk)
    begin
        if (cell_take)
        begin
            em_cell_reg <= cell_data;
            em_slot_reg <= cell_slot;
        end
        if (issue)
        begin
            out_x_reg      <= px ? em_cell_reg.x1 : em_cell_reg.x0;
            out_y_reg      <= py ? em_cell_reg.y1 : em_cell_reg.y0;
            out_depth_reg  <= em_cell_reg.depth;
            out_index_reg  <= em_cell_reg.base + {20'd0, em_corner_reg};
            out_corner_reg <= em_corner_reg;
            out_last_reg   <= (em_corner_reg == 2'd3);
        end
    end

    // Texture coordinate table; the read data only moves when a corner issues,
    // so it stays put while the output is stalled.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            tbl_q_reg <= tbl_mem[{em_slot_reg, em_corner_reg}];
        end
    end

    assign out_valid    = out_valid_reg;
    assign pos_x        = out_x_reg;
    assign pos_y        = out_y_reg;
    assign depth_step   = out_depth_reg;
    assign tex_u        = tbl_q_reg[31:16];
    assign tex_v        = tbl_q_reg[15:0];
    assign vertex_index = out_index_reg;
    assign corner       = out_corner_reg;
    assign last         = out_last_reg;

    // Loads are held off while a cell still has table reads to make.
    a_no_write_during_reads: assert property (
        @(posedge clk) disable iff (!rst_n)
        wr_en |-> !em_valid_reg
    ) else $error("table written while a cell is reading it");

    // After the fourth corner the sequencer is empty or starts a fresh quad.
    a_quad_restart: assert property (
        @(posedge clk) disable iff (!rst_n)
        (issue && em_corner_reg == 2'd3) |=> (!em_valid_reg || em_corner_reg == 2'd0)
    ) else $error("sequencer did not restart at corner zero");

    // The four vertices of a quad leave without gaps.
    a_no_gap_in_quad: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !out_last_reg) |=> out_valid_reg
    ) else $error("gap inside a quad");

endmodule

FILE: design/tile_quad_vertex_generator.sv
// Tile quad vertex generator: a cell item yields four vertices, one a cycle while the
// output is not stalled; the single result channel and table read port set that rate.
// A cell passes the front stage, the corner sequencer and the output register before its
// first vertex is shown. A load waits while an earlier cell still reads the table.
// Reset clears control state and configuration registers; the table is undefined until loaded.
// Top level: configuration registers, cell qualification and the multiply stage.
module tile_quad_vertex_generator
    import tqvg_pkg::*;
#(
    parameter int MAX_TILES = 1024,
    parameter int MAP_DIM   = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration port.
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    // Input channel.
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [9:0]         row,
    input  logic [9:0]         col,
    input  logic [15:0]        tile_id,
    input  logic [9:0]         slot,
    input  logic [1:0]         load_corner,
    input  logic [15:0]        load_u,
    input  logic [15:0]        load_v,
    // Result channel.
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [10:0]        depth_step,
    output logic [15:0]        tex_u,
    output logic [15:0]        tex_v,
    output logic [21:0]        vertex_index,
    output logic [1:0]         corner,
    output logic               last
);

    localparam int SLOT_W      = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int TABLE_DEPTH = MAX_TILES * 4;

    logic [1:0]         orientation_reg;
    logic [10:0]        tile_count_reg;
    logic [23:0]        hex_width_reg, hex_height_reg, sprite_height_reg;
    logic [22:0]        vcount_reg, vcount_next;

    logic               s1_valid_reg, s1_valid_next;
    logic [1:0]         s1_orient_reg;
    logic [9:0]         s1_row_reg, s1_col_reg;
    logic [SLOT_W-1:0]  s1_slot_reg;
    logic [21:0]        s1_base_reg;
    logic [35:0]        s1_hw3col_reg, s1_hw3col_next;
    logic [33:0]        s1_hhrow_reg, s1_hhrow_next;

    logic               in_accept;
    logic               cell_ok, cell_accept;
    logic               load_ok;
    logic               take, busy;
    logic [25:0]        hw3;
    cell_t              cell_data;

    logic signed [39:0] ox0, ox1, oy0, oy1;
    logic signed [39:0] idiff, isum, ix0, ix1, iy0, iy1;
    logic signed [39:0] hxb, hw2, hx0, hx1, hyb, sh40, hy0, hy1;

    // A cell gives output only with a known tile, inside the map and a used layout.
    assign cell_ok = (kind == KIND_CELL)
                  && (tile_id != 16'd0)
                  && (tile_id <= {5'd0, tile_count_reg})
                  && (17'(tile_id) <= 17'(MAX_TILES))
                  && (17'(row) < 17'(MAP_DIM))
                  && (17'(col) < 17'(MAP_DIM))
                  && (orientation_reg != 2'd3);
    assign load_ok = (kind == KIND_LOAD) && (17'(slot) < 17'(MAX_TILES));

    // Hold the input while the front stage is full, and hold loads while any
    // cell has table reads outstanding.
    assign in_stall = (s1_valid_reg && !take)
                   || ((kind == KIND_LOAD) && (s1_valid_reg || busy));
    assign in_accept   = in_valid && !in_stall;
    assign cell_accept = in_accept && cell_ok;

    // Running vertex count: cleared by a start item, four per emitted quad.
    always_comb
    begin
        vcount_next = vcount_reg;
        if (in_accept && kind == KIND_START)
        begin
            vcount_next = 23'd0;
        end
        else if (cell_accept)
        begin
            vcount_next = vcount_reg + 23'd4;
        end
    end

    // Front stage occupancy.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cell_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (take)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Hexagonal products: 3*hex_width*col and hex_height*row.
    assign hw3            = {2'd0, hex_width_reg} + {1'd0, hex_width_reg, 1'b0};
    assign s1_hw3col_next = 36'(hw3) * 36'(col);
    assign s1_hhrow_next  = 34'(hex_height_reg) * 34'(row);

    // Configuration and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orientation_reg   <= ORIENT_ORTHO;
            tile_count_reg    <= 11'd0;
            hex_width_reg     <= UNIT_Q8_16;
            hex_height_reg    <= UNIT_Q8_16;
            sprite_height_reg <= UNIT_Q8_16;
            vcount_reg        <= 23'd0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ORIENTATION:   orientation_reg   <= cfg_data[1:0];
                    REG_TILE_COUNT:    tile_count_reg    <= cfg_data[10:0];
                    REG_HEX_WIDTH:     hex_width_reg     <= cfg_data;
                    REG_HEX_HEIGHT:    hex_height_reg    <= cfg_data;
                    REG_SPRITE_HEIGHT: sprite_height_reg <= cfg_data;
                    default:           ;
                endcase
            end
            vcount_reg   <= vcount_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Front stage payload.
    always_ff @(posedge clk)
    begin
        if (cell_accept)
        begin
            s1_orient_reg <= orientation_reg;
            s1_row_reg    <= row;
            s1_col_reg    <= col;
            s1_slot_reg   <= SLOT_W'(tile_id - 16'd1);
            s1_base_reg   <= vcount_reg[21:0];
            s1_hw3col_reg <= s1_hw3col_next;
            s1_hhrow_reg  <= s1_hhrow_next;
        end
    end

    // Corner coordinates for offsets 0 and 1 in each layout.
    always_comb
    begin
        // Orthogonal: whole world units.
        ox0 = $signed({14'd0, s1_col_reg, 16'd0});
        ox1 = ox0 + 40'sh10000;
        oy0 = -$signed({14'd0, s1_row_reg, 16'd0});
        oy1 = oy0 - 40'sh10000;

        // Isometric: half steps across, quarter steps down.
        idiff = $signed({30'd0, s1_col_reg}) - $signed({30'd0, s1_row_reg});
        isum  = $signed({30'd0, s1_col_reg}) + $signed({30'd0, s1_row_reg});
        ix0   = (idiff <<< 15) - 40'sd32768;
        ix1   = ix0 + 40'sd65536;
        iy0   = -(isum <<< 14) - 40'sd32768;
        iy1   = iy0 + 40'sd65536;

        // Hexagonal: quarter and half steps, rounded once, ties upwards.
        hxb  = $signed({4'd0, s1_hw3col_reg});
        hw2  = $signed({15'd0, hex_width_reg, 1'b0});
        hx0  = (hxb - hw2 + 40'sd2) >>> 2;
        hx1  = (hxb + hw2 + 40'sd2) >>> 2;
        hyb  = -($signed({5'd0, s1_hhrow_reg, 1'b0})
               + (s1_col_reg[0] ? $signed({16'd0, hex_height_reg}) : 40'sd0));
        sh40 = $signed({16'd0, sprite_height_reg});
        hy0  = (hyb - sh40 + 40'sd1) >>> 1;
        hy1  = (hyb + sh40 + 40'sd1) >>> 1;

        cell_data.orient = s1_orient_reg;
        cell_data.base   = s1_base_reg;
        case (s1_orient_reg)
            ORIENT_ISO:
            begin
                cell_data.x0    = sat32(ix0);
                cell_data.x1    = sat32(ix1);
                cell_data.y0    = sat32(iy0);
                cell_data.y1    = sat32(iy1);
                cell_data.depth = {1'b0, s1_row_reg} + {1'b0, s1_col_reg};
            end
            ORIENT_HEX:
            begin
                cell_data.x0    = sat32(hx0);
                cell_data.x1    = sat32(hx1);
                cell_data.y0    = sat32(hy0);
                cell_data.y1    = sat32(hy1);
                cell_data.depth = {1'b0, s1_row_reg};
            end
            default:
            begin
                cell_data.x0    = sat32(ox0);
                cell_data.x1    = sat32(ox1);
                cell_data.y0    = sat32(oy0);
                cell_data.y1    = sat32(oy1);
                cell_data.depth = 11'd0;
            end
        endcase
    end

    tqvg_emit #(
        .SLOT_W      (SLOT_W),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (s1_valid_reg),
        .cell_data    (cell_data),
        .cell_slot    (s1_slot_reg),
        .cell_take    (take),
        .busy         (busy),
        .wr_en        (in_accept && load_ok),
        .wr_addr      ({SLOT_W'(slot), load_corner}),
        .wr_data      ({load_u, load_v}),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .depth_step   (depth_step),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .vertex_index (vertex_index),
        .corner       (corner),
        .last         (last)
    );

endmodule
